@@ rtl/piecewise_linear_interpolator_unit_macros.svh @@
// Assertion macros for the piecewise linear interpolator unit.
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_UNIT_MACROS_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_UNIT_MACROS_SVH

// Same-cycle implication on clk, masked while arst_n is low.
`define PLIU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication on clk, masked while arst_n is low.
`define PLIU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/pliu_pkg.sv @@
// Shared types and constants of the piecewise linear interpolator unit.
package pliu_pkg;

	localparam int NUM_W    = 64;
	localparam int DEN_W    = 32;
	localparam int QUO_W    = 36;
	localparam int DIV_ITER = QUO_W / 2;
	localparam int HI_W     = NUM_W - QUO_W;
	localparam int QCAP_W   = 34;
	localparam logic [QCAP_W-1:0] TERM_CAP = {1'b1, {(QCAP_W-1){1'b0}}};

	localparam logic [2:0] STAT_INTERP = 3'd0;
	localparam logic [2:0] STAT_BELOW  = 3'd1;
	localparam logic [2:0] STAT_ABOVE  = 3'd2;
	localparam logic [2:0] STAT_NOSEG  = 3'd3;
	localparam logic [2:0] STAT_ZEROW  = 3'd4;

	typedef struct packed {
		logic clear;
		logic load_v;
		logic wr_req;
		logic rd_en;
		logic eval;
		logic pair;
		logic first;
		logic last;
		logic calc;
		logic mult;
		logic div_start;
		logic out_load;
	} pliu_cmd_t;

	typedef struct packed {
		logic noseg;
		logic div_done;
	} pliu_sts_t;

endpackage

@@ rtl/piecewise_linear_interpolator_unit.sv @@
// Piecewise linear interpolator unit: top level.
// Table write: no result. Query: table scan over the effective point count at one entry per cycle,
// then 18 divider iterations; the iterations are skipped on quotient overflow or a zero-width segment,
// and the multiply and divide are skipped when no segment is found.
// The next transaction is taken in the cycle after the result is loaded, even if the result still waits.
// arst_n clears control state and sets points_in_use to 2; table contents are not reset.
module piecewise_linear_interpolator_unit #(
	parameter int MAX_POINTS = 16,
	parameter int FRAC_BITS  = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [103:0] s_tdata,  // entry_index[3:0], entry_x[35:4], entry_fx[67:36], query_value[99:68], zero pad
	input  logic         s_tuser,  // func
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [31:0]  m_tdata,  // mapped_value
	output logic [2:0]   m_tuser,  // status
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [4:0]   cfg_data   // points_in_use
);
	import pliu_pkg::*;

	`include "piecewise_linear_interpolator_unit_macros.svh"

	localparam int AW = $clog2(MAX_POINTS);
	localparam logic [31:0] NEG_ONE = -(32'sd1 <<< FRAC_BITS);

	pliu_cmd_t       cmd;
	pliu_sts_t       sts;
	logic [AW-1:0]   rd_addr;
	logic signed [31:0] mapped_value;

	pliu_ctrl #(
		.MAX_POINTS (MAX_POINTS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_valid   (s_tvalid),
		.s_func    (s_tuser),
		.s_ready   (s_tready),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.cfg_ready (cfg_ready),
		.m_valid   (m_tvalid),
		.m_ready   (m_tready),
		.cmd       (cmd),
		.rd_addr   (rd_addr),
		.sts       (sts)
	);

	pliu_dp #(
		.MAX_POINTS (MAX_POINTS),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.rd_addr      (rd_addr),
		.entry_index  (s_tdata[3:0]),
		.entry_x      (signed'(s_tdata[35:4])),
		.entry_fx     (signed'(s_tdata[67:36])),
		.query_value  (signed'(s_tdata[99:68])),
		.mapped_value (mapped_value),
		.status       (m_tuser)
	);

	assign m_tdata = mapped_value;

	`PLIU_ASSERT_NEXT(a_query_blocks_input, s_tvalid && s_tready && s_tuser, !s_tready, "query transaction did not take the unit busy")
	`PLIU_ASSERT_NEXT(a_write_no_result, s_tvalid && s_tready && !s_tuser && !m_tvalid, !m_tvalid, "table write produced a result")
	`PLIU_ASSERT_NOW(a_noseg_value, m_tvalid && (m_tuser == STAT_NOSEG), m_tdata == NEG_ONE, "no-segment result is not minus one")

endmodule

@@ rtl/pliu_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pliu_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ rtl/pliu_div.sv @@
// Iterative unsigned divider, two quotient bits per cycle, with overflow detect.
module pliu_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [pliu_pkg::NUM_W-1:0]   dividend,
	input  logic [pliu_pkg::DEN_W-1:0]   divisor,
	output logic [pliu_pkg::QUO_W-1:0]   quotient,
	output logic                         ovf,
	output logic                         done
);
	import pliu_pkg::*;

	localparam int CW = $clog2(DIV_ITER);

	logic              busy_q;
	logic              done_q;
	logic              ovf_q;
	logic [CW-1:0]     cnt_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W-1:0]  rem_q;
	logic [QUO_W-1:0]  dvd_q;
	logic [QUO_W-1:0]  quo_q;

	logic [DEN_W:0]    r1, r2, r1m, r2m;
	logic              ge1, ge2;
	logic              ovf_start;

	assign ovf_start = {{(DEN_W-HI_W){1'b0}}, dividend[NUM_W-1:QUO_W]} >= divisor;

	always_comb begin
		r1  = {rem_q, dvd_q[QUO_W-1]};
		ge1 = r1 >= {1'b0, den_q};
		r1m = ge1 ? (r1 - {1'b0, den_q}) : r1;
		r2  = {r1m[DEN_W-1:0], dvd_q[QUO_W-2]};
		ge2 = r2 >= {1'b0, den_q};
		r2m = ge2 ? (r2 - {1'b0, den_q}) : r2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= !ovf_start;
				done_q <= ovf_start;
				cnt_q  <= CW'(DIV_ITER - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ovf_q <= ovf_start;
			den_q <= divisor;
			rem_q <= {{(DEN_W-HI_W){1'b0}}, dividend[NUM_W-1:QUO_W]};
			dvd_q <= dividend[QUO_W-1:0];
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= r2m[DEN_W-1:0];
			dvd_q <= {dvd_q[QUO_W-3:0], 2'b00};
			quo_q <= {quo_q[QUO_W-3:0], ge1, ge2};
		end
	end

	assign quotient = quo_q;
	assign ovf      = ovf_q;
	assign done     = done_q;

endmodule

@@ rtl/pliu_dp.sv @@
// Datapath: breakpoint table, segment search, line evaluation and result register.
module pliu_dp #(
	parameter int MAX_POINTS = 16,
	parameter int FRAC_BITS  = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  pliu_pkg::pliu_cmd_t             cmd,
	output pliu_pkg::pliu_sts_t             sts,
	input  logic [$clog2(MAX_POINTS)-1:0]   rd_addr,
	input  logic [3:0]                      entry_index,
	input  logic signed [31:0]              entry_x,
	input  logic signed [31:0]              entry_fx,
	input  logic signed [31:0]              query_value,
	output logic signed [31:0]              mapped_value,
	output logic [2:0]                      status
);
	import pliu_pkg::*;

	localparam int AW = $clog2(MAX_POINTS);
	localparam logic signed [31:0] NEG_ONE = -(32'sd1 <<< FRAC_BITS);

	logic              wr_en;
	logic [63:0]       rd_data;
	logic signed [31:0] rd_x, rd_fx;

	logic signed [31:0] v_q;
	logic signed [31:0] cur_x_q, cur_fx_q;
	logic signed [31:0] seg_xa_q, seg_fa_q, seg_xb_q, seg_fb_q;
	logic              below_q, above_q, found_q;
	logic              below_hit, above_hit, brk_hit, seg_ld;

	logic signed [32:0] dy, dx, da;
	logic [31:0]       mag_dy_s1, mag_a_s1, mag_dx_s1;
	logic              neg_s1, negz_s1, dxz_s1;
	logic [NUM_W-1:0]  num_s2;

	logic [QUO_W-1:0]  quo;
	logic              div_ovf;
	logic              div_done;

	logic [QCAP_W-1:0] qs;
	logic              neg_f;
	logic signed [34:0] term;
	logic signed [35:0] sum;
	logic signed [31:0] sat;
	logic [2:0]        stat_n;

	assign wr_en = cmd.wr_req && (32'(entry_index) < MAX_POINTS);

	pliu_ram #(
		.WIDTH (64),
		.DEPTH (MAX_POINTS)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (AW'(entry_index)),
		.wr_data ({entry_fx, entry_x}),
		.rd_en   (cmd.rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign rd_x  = signed'(rd_data[31:0]);
	assign rd_fx = signed'(rd_data[63:32]);

	// cur_* holds the previous entry while the next one arrives
	always_comb begin
		below_hit = cmd.eval && cmd.pair && cmd.first && (v_q < cur_x_q);
		above_hit = cmd.eval && cmd.pair && cmd.last && (v_q > rd_x);
		brk_hit   = cmd.eval && cmd.pair && !found_q && (cur_x_q <= v_q) && (v_q <= rd_x);
		seg_ld    = below_hit || ((above_hit || brk_hit) && !below_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			below_q <= 1'b0;
			above_q <= 1'b0;
			found_q <= 1'b0;
		end else if (cmd.clear) begin
			below_q <= 1'b0;
			above_q <= 1'b0;
			found_q <= 1'b0;
		end else begin
			below_q <= below_q | below_hit;
			above_q <= above_q | above_hit;
			found_q <= found_q | brk_hit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_v) begin
			v_q <= query_value;
		end
		if (cmd.eval) begin
			cur_x_q  <= rd_x;
			cur_fx_q <= rd_fx;
		end
		if (seg_ld) begin
			seg_xa_q <= cur_x_q;
			seg_fa_q <= cur_fx_q;
			seg_xb_q <= rd_x;
			seg_fb_q <= rd_fx;
		end
	end

	assign sts.noseg    = !below_q && !above_q && !found_q;
	assign sts.div_done = div_done;

	always_comb begin
		dy = 33'(seg_fb_q) - 33'(seg_fa_q);
		dx = 33'(seg_xb_q) - 33'(seg_xa_q);
		da = 33'(v_q) - 33'(seg_xa_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			mag_dy_s1 <= dy[32] ? 32'(-dy) : dy[31:0];
			mag_a_s1  <= da[32] ? 32'(-da) : da[31:0];
			mag_dx_s1 <= dx[32] ? 32'(-dx) : dx[31:0];
			neg_s1    <= dy[32] ^ da[32] ^ dx[32];
			negz_s1   <= dy[32] ^ da[32];
			dxz_s1    <= (dx == '0);
		end
		if (cmd.mult) begin
			num_s2 <= NUM_W'(mag_dy_s1) * NUM_W'(mag_a_s1);
		end
	end

	pliu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (num_s2),
		.divisor  (mag_dx_s1),
		.quotient (quo),
		.ovf      (div_ovf),
		.done     (div_done)
	);

	always_comb begin
		if (div_ovf || dxz_s1 || (quo > QUO_W'(TERM_CAP))) begin
			qs = TERM_CAP;
		end else begin
			qs = quo[QCAP_W-1:0];
		end
		neg_f = dxz_s1 ? negz_s1 : neg_s1;
		if (num_s2 == '0) begin
			term = '0;
		end else if (neg_f) begin
			term = -signed'({1'b0, qs});
		end else begin
			term = signed'({1'b0, qs});
		end
		sum = 36'(seg_fa_q) + 36'(term);
		if (sum > 36'sh0_7FFF_FFFF) begin
			sat = 32'sh7FFF_FFFF;
		end else if (sum < -36'sh0_8000_0000) begin
			sat = -32'sh8000_0000;
		end else begin
			sat = sum[31:0];
		end
		if (sts.noseg) begin
			stat_n = STAT_NOSEG;
		end else if (dxz_s1) begin
			stat_n = STAT_ZEROW;
		end else if (below_q) begin
			stat_n = STAT_BELOW;
		end else if (above_q) begin
			stat_n = STAT_ABOVE;
		end else begin
			stat_n = STAT_INTERP;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			mapped_value <= sts.noseg ? NEG_ONE : sat;
			status       <= stat_n;
		end
	end

endmodule

@@ rtl/pliu_ctrl.sv @@
// Controller: sequences table writes, the scan, the arithmetic and the output handshake.
module pliu_ctrl #(
	parameter int MAX_POINTS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_valid,
	input  logic                            s_func,
	output logic                            s_ready,
	input  logic                            cfg_valid,
	input  logic [4:0]                      cfg_data,
	output logic                            cfg_ready,
	output logic                            m_valid,
	input  logic                            m_ready,
	output pliu_pkg::pliu_cmd_t             cmd,
	output logic [$clog2(MAX_POINTS)-1:0]   rd_addr,
	input  pliu_pkg::pliu_sts_t             sts
);
	import pliu_pkg::*;

	localparam int AW = $clog2(MAX_POINTS);
	localparam int NW = ((AW > 5) ? AW : 5) + 1;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_SCAN  = 8'b0000_0010,
		S_DRAIN = 8'b0000_0100,
		S_SETUP = 8'b0000_1000,
		S_MULT  = 8'b0001_0000,
		S_DIVGO = 8'b0010_0000,
		S_DIVW  = 8'b0100_0000,
		S_FIN   = 8'b1000_0000
	} pliu_state_t;

	pliu_state_t     state_q, state_n;
	logic [4:0]      points_q;
	logic [AW-1:0]   cnt_q;
	logic [NW-1:0]   pts_w, n_eff;
	logic [AW-1:0]   last_idx;
	logic            eval_s1, pair_s1, first_s1, last_s1;
	logic            m_valid_q;
	logic            in_acc, out_free;

	assign cfg_ready = 1'b1;
	assign s_ready   = (state_q == S_IDLE);
	assign in_acc    = s_valid && s_ready;
	assign out_free  = !m_valid_q || m_ready;
	assign m_valid   = m_valid_q;
	assign rd_addr   = cnt_q;

	always_comb begin
		pts_w = NW'(points_q);
		if (pts_w < NW'(2)) begin
			n_eff = NW'(2);
		end else if (pts_w > NW'(MAX_POINTS)) begin
			n_eff = NW'(MAX_POINTS);
		end else begin
			n_eff = pts_w;
		end
		last_idx = AW'(n_eff - NW'(1));
	end

	always_comb begin
		state_n = state_q;
		cmd     = '0;
		cmd.eval  = eval_s1;
		cmd.pair  = pair_s1;
		cmd.first = first_s1;
		cmd.last  = last_s1;
		case (state_q)
			S_IDLE: begin
				cmd.wr_req = in_acc && !s_func;
				if (in_acc && s_func) begin
					cmd.load_v = 1'b1;
					cmd.clear  = 1'b1;
					state_n    = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.rd_en = 1'b1;
				if (cnt_q == last_idx) begin
					state_n = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_n = S_SETUP;
			end
			S_SETUP: begin
				cmd.calc = 1'b1;
				state_n  = sts.noseg ? S_FIN : S_MULT;
			end
			S_MULT: begin
				cmd.mult = 1'b1;
				state_n  = S_DIVGO;
			end
			S_DIVGO: begin
				cmd.div_start = 1'b1;
				state_n       = S_DIVW;
			end
			S_DIVW: begin
				if (sts.div_done) begin
					state_n = S_FIN;
				end
			end
			S_FIN: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_n      = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			points_q  <= 5'd2;
			cnt_q     <= '0;
			eval_s1   <= 1'b0;
			pair_s1   <= 1'b0;
			first_s1  <= 1'b0;
			last_s1   <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cfg_valid && cfg_ready) begin
				points_q <= cfg_data;
			end
			if (state_q == S_SCAN) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			eval_s1  <= (state_q == S_SCAN);
			pair_s1  <= (cnt_q != '0);
			first_s1 <= (cnt_q == AW'(1));
			last_s1  <= (cnt_q == last_idx);
			if (cmd.out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_ready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ sim/piecewise_linear_interpolator_unit_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the piecewise linear interpolator unit: directed table, then random phases.
module piecewise_linear_interpolator_unit_tb;
	import pliu_pkg::*;

	localparam int MAX_POINTS  = 16;
	localparam int FRAC_BITS   = 16;
	localparam int SETTLE      = 48;
	localparam int HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES      = 8;
	localparam int MIXED_ITEMS = 40;
	localparam int DIR_ROWS    = 28;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	localparam longint Q_MAX = 64'sd2147483647;
	localparam longint Q_MIN = -64'sd2147483648;
	localparam bit [63:0] QUOT_CAP = 64'(TERM_CAP);

	typedef enum logic [1:0] {ROW_WRITE, ROW_QUERY, ROW_POINTS} row_kind_t;

	typedef struct packed {
		logic        func;
		logic [3:0]  idx;
		logic [31:0] x;
		logic [31:0] fx;
		logic [31:0] q;
	} item_t;

	typedef struct packed {
		logic [31:0] mapped;
		logic [2:0]  status;
	} mapping_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [3:0]  idx;
		logic [31:0] a;
		logic [31:0] b;
		logic        pinned;
		mapping_t    want;
	} dir_row_t;

	// write: idx, a = x, b = fx; query: a = value; points: a[4:0]
	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		'{ROW_WRITE,  4'd0, 32'h0000_0000, 32'h0000_0000, 1'b0, '{32'h0, STAT_INTERP}},
		'{ROW_WRITE,  4'd1, 32'h0001_0000, 32'h0002_0000, 1'b0, '{32'h0, STAT_INTERP}},
		'{ROW_QUERY,  4'd0, 32'h0000_8000, 32'h0, 1'b1, '{32'h0001_0000, STAT_INTERP}},
		'{ROW_QUERY,  4'd0, 32'h0000_0000, 32'h0, 1'b1, '{32'h0000_0000, STAT_INTERP}},
		'{ROW_QUERY,  4'd0, 32'h0001_0000, 32'h0, 1'b1, '{32'h0002_0000, STAT_INTERP}},
		'{ROW_QUERY,  4'd0, 32'hFFFF_0000, 32'h0, 1'b1, '{32'hFFFE_0000, STAT_BELOW}},
		'{ROW_QUERY,  4'd0, 32'h0002_0000, 32'h0, 1'b1, '{32'h0004_0000, STAT_ABOVE}},
		'{ROW_QUERY,  4'd0, 32'h8000_0000, 32'h0, 1'b1, '{32'h8000_0000, STAT_BELOW}},
		'{ROW_QUERY,  4'd0, 32'h7FFF_FFFF, 32'h0, 1'b1, '{32'h7FFF_FFFF, STAT_ABOVE}},
		'{ROW_POINTS, 4'd0, 32'd0,         32'h0, 1'b0, '{32'h0, STAT_INTERP}},
		'{ROW_QUERY,  4'd0, 32'h0001_8000, 32'h0, 1'b1, '{32'h0003_0000, STAT_ABOVE}},
		'{ROW_WRITE,  4'd1, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0, '{32'h0, STAT_INTERP}},
		'{ROW_QUERY,  4'd0, 32'h0000_0000, 32'h0, 1'b1, '{32'h0000_0000, STAT_ZEROW}},
		'{ROW_QUERY,  4'd0, 32'h0000_0001, 32'h0, 1'b1, '{32'h7FFF_FFFF, STAT_ZEROW}},
		'{ROW_QUERY,  4'd0, 32'hFFFF_FFFF, 32'h0, 1'b1, '{32'h8000_0000, STAT_ZEROW}},
		'{ROW_POINTS, 4'd0, 32'd1,         32'h0, 1'b0, '{32'h0, STAT_INTERP}},
		'{ROW_WRITE,  4'd0, 32'h8000_0000, 32'h8000_0000, 1'b0, '{32'h0, STAT_INTERP}},
		'{ROW_WRITE,  4'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '{32'h0, STAT_INTERP}},
		'{ROW_QUERY,  4'd0, 32'h0001_0000, 32'h0, 1'b0, '{32'h0, STAT_INTERP}},
		'{ROW_WRITE,  4'd2, 32'hFFFF_0000, 32'h1234_5678, 1'b0, '{32'h0, STAT_INTERP}},
		'{ROW_WRITE,  4'd3, 32'h0005_0000, 32'hEDCB_A987, 1'b0, '{32'h0, STAT_INTERP}},
		'{ROW_POINTS, 4'd0, 32'd4,         32'h0, 1'b0, '{32'h0, STAT_INTERP}},
		'{ROW_QUERY,  4'd0, 32'h0003_0000, 32'h0, 1'b0, '{32'h0, STAT_INTERP}},
		'{ROW_QUERY,  4'd0, 32'h7FFF_FFFF, 32'h0, 1'b0, '{32'h0, STAT_INTERP}},
		'{ROW_QUERY,  4'd0, 32'h8000_0000, 32'h0, 1'b1, '{32'h8000_0000, STAT_INTERP}},
		'{ROW_QUERY,  4'd0, 32'h0006_0000, 32'h0, 1'b0, '{32'h0, STAT_INTERP}},
		'{ROW_POINTS, 4'd0, 32'd3,         32'h0, 1'b0, '{32'h0, STAT_INTERP}},
		'{ROW_QUERY,  4'd0, 32'h0000_0000, 32'h0, 1'b0, '{32'h0, STAT_INTERP}}
	};

	localparam logic [4:0] PHASE_POINTS [6] = '{5'd31, 5'd16, 5'd2, 5'd17, 5'd1, 5'd0};

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [103:0] s_tdata;  // entry_index[3:0], entry_x[35:4], entry_fx[67:36], query_value[99:68], zero pad
	logic         s_tuser;  // func
	logic         m_tvalid;
	logic         m_tready;
	logic [31:0]  m_tdata;  // mapped_value
	logic [2:0]   m_tuser;  // status
	logic         cfg_valid;
	logic         cfg_ready;
	logic [4:0]   cfg_data;

	int       bp_x  [MAX_POINTS];
	int       bp_fx [MAX_POINTS];
	logic [4:0] points_cfg = 5'd2;
	mapping_t expected_maps [$];
	int       mismatch_count = 0;
	int       cycle_count = 0;
	bit       quiet = 1'b0;
	bit       hold_off_req = 1'b0;

	piecewise_linear_interpolator_unit #(
		.MAX_POINTS(MAX_POINTS),
		.FRAC_BITS (FRAC_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	function automatic bit [63:0] mag64(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic int clamp32(input longint v);
		if (v > Q_MAX)
			return int'(Q_MAX);
		if (v < Q_MIN)
			return int'(Q_MIN);
		return int'(v);
	endfunction

	// fa + (v - xa) * (fb - fa) / (xb - xa), exact product, quotient capped
	function automatic int seg_map(input longint xa, fa, xb, fb, v, output bit zero_w);
		longint    dy;
		longint    dx;
		longint    span;
		longint    term;
		bit [63:0] num;
		bit [63:0] quo;
		bit        neg;
		dy = fb - fa;
		dx = xb - xa;
		span = v - xa;
		num = mag64(dy) * mag64(span);
		neg = ((dy < 0) != (span < 0)) != (dx < 0);
		zero_w = (dx == 0);
		term = 0;
		if (num != 0) begin
			if (dx == 0) begin
				quo = QUOT_CAP;
				neg = (dy < 0) != (span < 0);
			end else begin
				quo = num / mag64(dx);
				if (quo > QUOT_CAP)
					quo = QUOT_CAP;
			end
			term = neg ? -longint'(quo) : longint'(quo);
		end
		return clamp32(fa + term);
	endfunction

	function automatic int points_eff();
		if (points_cfg < 2)
			return 2;
		if (points_cfg > MAX_POINTS)
			return MAX_POINTS;
		return int'(points_cfg);
	endfunction

	function automatic mapping_t map_query(input logic [31:0] q_bits);
		int         n;
		int         i;
		int         qi;
		int         res;
		longint     v;
		logic [2:0] st;
		bit         zw;
		bit         found;
		mapping_t   r;
		n = points_eff();
		qi = q_bits;
		v = qi;
		zw = 1'b0;
		found = 1'b0;
		if (v < bp_x[0]) begin
			res = seg_map(bp_x[0], bp_fx[0], bp_x[1], bp_fx[1], v, zw);
			st = STAT_BELOW;
		end else if (v > bp_x[n-1]) begin
			res = seg_map(bp_x[n-2], bp_fx[n-2], bp_x[n-1], bp_fx[n-1], v, zw);
			st = STAT_ABOVE;
		end else begin
			res = -(1 << FRAC_BITS);
			st = STAT_NOSEG;
			for (i = 0; i + 1 < n && !found; i++) begin
				if (v >= bp_x[i] && v <= bp_x[i+1]) begin
					res = seg_map(bp_x[i], bp_fx[i], bp_x[i+1], bp_fx[i+1], v, zw);
					st = STAT_INTERP;
					found = 1'b1;
				end
			end
		end
		if (zw)
			st = STAT_ZEROW;
		r.mapped = res;
		r.status = st;
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(15);
		if (r < 9)
			return 0;
		if (r < 14)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	// tvalid is left high after a transaction so back-to-back items need no second update
	task automatic push_item(input item_t it, input bit pinned, input mapping_t want);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= it.func;
		s_tdata  <= {4'b0, it.q, it.fx, it.x, it.idx};
		do @(posedge clk); while (!s_tready);
		if (it.func == FUNC_WRITE) begin
			bp_x[it.idx]  = it.x;
			bp_fx[it.idx] = it.fx;
		end else begin
			expected_maps.push_back(pinned ? want : map_query(it.q));
		end
	endtask

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (expected_maps.size() != 0);
	endtask

	// a table write leaves nothing in the queue, so allow the unit to go idle
	task automatic set_points(input logic [4:0] value);
		wait_drain();
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		points_cfg = value;
		cfg_valid <= 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("piecewise_linear_interpolator_unit_tb: FAIL");
		$finish;
	end

	initial begin : result_sink
		int       stall;
		mapping_t want;
		stall = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				if (expected_maps.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: unexpected transaction, mapped %h status %0d",
							$time, m_tdata, m_tuser);
				end else begin
					want = expected_maps.pop_front();
					if (m_tdata !== want.mapped || m_tuser !== want.status) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("%0t: mapped %h status %0d, expected %h status %0d",
								$time, m_tdata, m_tuser, want.mapped, want.status);
					end
				end
			end
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				stall = HOLD_CYCLES;
			end
			if (stall > 0) begin
				stall--;
				m_tready <= 1'b0;
			end else begin
				stall = pick_gap();
				m_tready <= (stall == 0);
			end
		end
	end

	initial begin : stimulus
		int         k;
		int         j;
		int         r;
		int         n;
		int         style;
		int         step_lim;
		longint     pos;
		bit         big_fx;
		logic [4:0] pts;
		item_t      it;
		dir_row_t   row;

		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= FUNC_WRITE;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < DIR_ROWS; k++) begin
			row = DIRECTED[k];
			it = '0;
			case (row.kind)
				ROW_POINTS: set_points(row.a[4:0]);
				ROW_WRITE: begin
					it.func = FUNC_WRITE;
					it.idx  = row.idx;
					it.x    = row.a;
					it.fx   = row.b;
					push_item(it, 1'b0, '0);
				end
				default: begin
					it.func = FUNC_QUERY;
					it.q    = row.a;
					push_item(it, row.pinned, row.want);
				end
			endcase
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			quiet = (phase == 3);
			pts = (phase < 6) ? PHASE_POINTS[phase] : 5'($urandom_range(31));
			set_points(pts);
			n = points_eff();
			style = $urandom_range(3);
			big_fx = 1'($urandom_range(1));
			step_lim = (style == 0) ? 16 : (style == 1) ? (1 << 18) : (1 << 28);
			pos = -(longint'(step_lim) * 7) + longint'($urandom_range(1023));

			// reload the whole table: sorted with occasional repeats, or scrambled
			for (k = 0; k < MAX_POINTS; k++) begin
				it.func = FUNC_WRITE;
				it.idx  = 4'(k);
				it.q    = $urandom;
				it.x    = (style == 3) ? $urandom : clamp32(pos);
				it.fx   = big_fx ? $urandom : int'($urandom_range(1 << 21)) - (1 << 20);
				push_item(it, 1'b0, '0);
				if ($urandom_range(7) != 0)
					pos += $urandom_range(step_lim, 1);
			end

			if (phase == 2)
				hold_off_req = 1'b1;

			for (k = 0; k < MIXED_ITEMS; k++) begin
				if (phase == 4 && k == MIXED_ITEMS / 2)
					wait_drain();
				r = $urandom_range(9);
				j = $urandom_range(MAX_POINTS - 1);
				it.func = (r < 6) ? FUNC_QUERY : FUNC_WRITE;
				it.idx  = 4'($urandom);
				it.x    = $urandom;
				it.fx   = big_fx ? $urandom : int'($urandom_range(1 << 21)) - (1 << 20);
				it.q    = $urandom;
				if (r < 6) begin
					case ($urandom_range(5))
						1: it.q = bp_x[j];
						2: it.q = clamp32(longint'(bp_x[j]) + int'($urandom_range(16)) - 8);
						3: it.q = clamp32((longint'(bp_x[j]) + bp_x[(j + 1) % MAX_POINTS]) / 2);
						4: it.q = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
						5: begin
							if ($urandom_range(1))
								it.q = clamp32(longint'(bp_x[0])
									- longint'($urandom_range(1 << 20)));
							else
								it.q = clamp32(longint'(bp_x[n-1])
									+ longint'($urandom_range(1 << 20)));
						end
						default: ;
					endcase
				end else if (r < 8) begin
					// keep the order: place between the neighbours
					it.idx = 4'(j);
					if (j == 0)
						it.x = clamp32(longint'(bp_x[1]) - longint'($urandom_range(1 << 16)));
					else if (j == MAX_POINTS - 1)
						it.x = clamp32(longint'(bp_x[j-1]) + longint'($urandom_range(1 << 16)));
					else
						it.x = clamp32((longint'(bp_x[j-1]) + bp_x[j+1]) / 2);
				end else if (r == 8) begin
					// repeat the neighbour's x for a zero-width segment
					it.idx = 4'((j == 0) ? 1 : j);
					it.x   = bp_x[it.idx - 1];
				end
				push_item(it, 1'b0, '0);
			end
		end

		wait_drain();
		repeat (64) @(posedge clk);
		if (mismatch_count == 0)
			$display("piecewise_linear_interpolator_unit_tb: PASS");
		else
			$display("piecewise_linear_interpolator_unit_tb: FAIL");
		$finish;
	end

endmodule
